// ----- design/compound_text_encoder_assert.svh -----
// ----------------------------------------------------------------------------
// Compound text encoder assertion macros
// Clocked concurrent assertion wrappers; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef COMPOUND_TEXT_ENCODER_ASSERT_SVH
`define COMPOUND_TEXT_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked at every rising clock edge outside reset.
`define CTE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define CTE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define CTE_ASSERT(label, prop, msg)
`define CTE_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- design/cte_pkg.sv -----
// ----------------------------------------------------------------------------
// Compound text encoder package
// Shared types, codes and prefix tables of the compound text encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cte_pkg;

   // Operation codes.
   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_REINIT = 1'b1;

   // Character class codes.
   localparam logic [3:0] CLS_94SB   = 4'd0;
   localparam logic [3:0] CLS_94MB   = 4'd1;
   localparam logic [3:0] CLS_96SB   = 4'd2;
   localparam logic [3:0] CLS_96MB   = 4'd3;
   localparam logic [3:0] CLS_BIG5   = 4'd4;
   localparam logic [3:0] CLS_HKSCS  = 4'd5;
   localparam logic [3:0] CLS_GBK    = 4'd6;
   localparam logic [3:0] CLS_ISCII  = 4'd7;
   localparam logic [3:0] CLS_KOI8R  = 4'd8;
   localparam logic [3:0] CLS_KOI8U  = 4'd9;
   localparam logic [3:0] CLS_VISCII = 4'd10;

   // Designations: bits 9..8 tag, bits 7..0 final byte.
   localparam logic [9:0] DESIG_BIG5 = 10'h200;
   localparam logic [9:0] G0_RESET   = 10'h042;
   localparam logic [9:0] G1_RESET   = 10'h041;

   localparam logic [7:0] ESC_BYTE    = 8'h1B;
   localparam logic [7:0] DOLLAR_BYTE = 8'h24;
   localparam logic [7:0] G0_INTER    = 8'h28;
   localparam logic [7:0] G1_INTER    = 8'h2D;

   // Largest number of bytes one item produces.
   localparam int MAX_BYTES = 24;
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);

   // Header that goes in front of the code bytes.
   typedef enum logic [3:0] {
      HDR_NONE,
      HDR_G0_SB,
      HDR_G0_MB,
      HDR_G1_SB,
      HDR_G1_MB,
      HDR_BIG5,
      HDR_BIG5_OLD,
      HDR_GBK,
      HDR_ISCII,
      HDR_KOI8R,
      HDR_KOI8U,
      HDR_VISCII
   } hdr_type;

   // One input word as held in the input register.
   typedef struct packed {
      logic       op;
      logic [3:0] cls;
      logic [7:0] fin;
      logic [1:0] sz;
      logic [7:0] b0;
      logic [7:0] b1;
   } item_type;

   // One decoded job handed from the decoder to the emitter.
   typedef struct packed {
      hdr_type          hdr;
      logic [7:0]       fin;
      logic [CNT_W-1:0] hdr_len;
      logic [CNT_W-1:0] total;
      logic [7:0]       b0;
      logic [7:0]       b1;
   } job_type;

   typedef logic [7:0] byte_tab_type [MAX_BYTES];

   localparam byte_tab_type PFX_BIG5 = '{
      8'h1B, 8'h25, 8'h2F, 8'h32, 8'h80, 8'h89, 8'h62, 8'h69,
      8'h67, 8'h35, 8'h2D, 8'h30, 8'h02, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

   // Old-server form names the encoding twice.
   localparam byte_tab_type PFX_BIG5_OLD = '{
      8'h1B, 8'h25, 8'h2F, 8'h32, 8'h80, 8'h89, 8'h42, 8'h49,
      8'h47, 8'h35, 8'h2D, 8'h30, 8'h02, 8'h80, 8'h89, 8'h42,
      8'h49, 8'h47, 8'h35, 8'h2D, 8'h30, 8'h02, 8'h00, 8'h00};

   localparam byte_tab_type PFX_GBK = '{
      8'h1B, 8'h25, 8'h2F, 8'h32, 8'h80, 8'h88, 8'h67, 8'h62,
      8'h6B, 8'h2D, 8'h30, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

   localparam byte_tab_type PFX_ISCII = '{
      8'h1B, 8'h25, 8'h2F, 8'h31, 8'h80, 8'h8B, 8'h69, 8'h73,
      8'h63, 8'h69, 8'h69, 8'h2D, 8'h64, 8'h65, 8'h76, 8'h02,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

   localparam byte_tab_type PFX_KOI8R = '{
      8'h1B, 8'h25, 8'h2F, 8'h31, 8'h80, 8'h88, 8'h6B, 8'h6F,
      8'h69, 8'h38, 8'h2D, 8'h72, 8'h02, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

   localparam byte_tab_type PFX_KOI8U = '{
      8'h1B, 8'h25, 8'h2F, 8'h31, 8'h80, 8'h88, 8'h6B, 8'h6F,
      8'h69, 8'h38, 8'h2D, 8'h75, 8'h02, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

   localparam byte_tab_type PFX_VISCII = '{
      8'h1B, 8'h25, 8'h2F, 8'h31, 8'h80, 8'h8D, 8'h76, 8'h69,
      8'h73, 8'h63, 8'h69, 8'h69, 8'h31, 8'h2E, 8'h31, 8'h2D,
      8'h31, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

   // Number of header bytes for each header kind.
   function automatic logic [CNT_W-1:0] hdr_len(input hdr_type hdr);
      logic [CNT_W-1:0] len;
      case (hdr)
         HDR_NONE:     len = CNT_W'(0);
         HDR_G0_SB:    len = CNT_W'(3);
         HDR_G0_MB:    len = CNT_W'(4);
         HDR_G1_SB:    len = CNT_W'(3);
         HDR_G1_MB:    len = CNT_W'(4);
         HDR_BIG5:     len = CNT_W'(13);
         HDR_BIG5_OLD: len = CNT_W'(22);
         HDR_GBK:      len = CNT_W'(12);
         HDR_ISCII:    len = CNT_W'(16);
         HDR_KOI8R:    len = CNT_W'(13);
         HDR_KOI8U:    len = CNT_W'(13);
         HDR_VISCII:   len = CNT_W'(18);
         default:      len = CNT_W'(0);
      endcase
      return len;
   endfunction

   // Header byte at position idx; fin is the final byte of a designation.
   function automatic logic [7:0] hdr_byte(input hdr_type hdr,
                                           input logic [CNT_W-1:0] idx,
                                           input logic [7:0] fin);
      logic [7:0] b;
      case (hdr)
         HDR_G0_SB, HDR_G1_SB: begin
            if (idx == CNT_W'(0)) begin
               b = ESC_BYTE;
            end else if (idx == CNT_W'(1)) begin
               b = (hdr == HDR_G0_SB) ? G0_INTER : G1_INTER;
            end else begin
               b = fin;
            end
         end
         HDR_G0_MB, HDR_G1_MB: begin
            if (idx == CNT_W'(0)) begin
               b = ESC_BYTE;
            end else if (idx == CNT_W'(1)) begin
               b = DOLLAR_BYTE;
            end else if (idx == CNT_W'(2)) begin
               b = (hdr == HDR_G0_MB) ? G0_INTER : G1_INTER;
            end else begin
               b = fin;
            end
         end
         HDR_BIG5:     b = PFX_BIG5[idx];
         HDR_BIG5_OLD: b = PFX_BIG5_OLD[idx];
         HDR_GBK:      b = PFX_GBK[idx];
         HDR_ISCII:    b = PFX_ISCII[idx];
         HDR_KOI8R:    b = PFX_KOI8R[idx];
         HDR_KOI8U:    b = PFX_KOI8U[idx];
         HDR_VISCII:   b = PFX_VISCII[idx];
         default:      b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ----- design/compound_text_encoder.sv -----
// ----------------------------------------------------------------------------
// Compound text encoder
// Encodes classified characters into compound text bytes, with designation
// escapes and extended-segment prefixes.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  tuser: op, class; tdata: char
//   rsp      out        rsp_tvalid/rsp_tready  tdata: byte; tlast: last byte
//   csr      in         csr_valid/csr_ready    csr_data: Big5 old-server mode
//
// An item passes the input register and then the emitter, which sends its bytes
// (1 to 24) one at a time; the emitter's single byte path sets the rate, so
// one-byte characters run at one item per cycle while rsp is not stalled.
// Reinitialize and unsupported items produce no bytes and skip the emitter.
// The first byte goes through the input, job and output registers.
// Reset is synchronous and restores G0 to ASCII, G1 to Latin-1, mode to 0.
// A stalled rsp holds its word while the emitter and input register fill up.
// ----------------------------------------------------------------------------
`default_nettype none

module compound_text_encoder
   import cte_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Input character words.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // final_byte, char_size, code_byte_0, code_byte_1
   input  wire logic [4:0]  req_tuser,  // operation, char_class
   // Output bytes.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // out_byte
   output logic             rsp_tlast,
   // Configuration register write.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data
);

   item_type item;
   job_type  job;
   logic     job_valid;
   logic     job_ready;

   // Unpack the input word.
   always_comb begin
      item.op  = req_tuser[0];
      item.cls = req_tuser[4:1];
      item.fin = req_tdata[7:0];
      item.sz  = req_tdata[9:8];
      item.b0  = req_tdata[17:10];
      item.b1  = req_tdata[25:18];
   end

   assign csr_ready = 1'b1;

   cte_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job)
   );

   cte_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- design/cte_decode.sv -----
// ----------------------------------------------------------------------------
// Compound text decoder stage
// Holds the input word and the G0/G1 designations, and turns each supported
// character into a job: a header kind plus the code bytes to send.
// ----------------------------------------------------------------------------
`default_nettype none

module cte_decode
   import cte_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     csr_valid,
   input  wire logic     csr_data,
   input  wire logic     item_valid,
   output logic          item_ready,
   input  wire item_type item,
   output logic          job_valid,
   input  wire logic     job_ready,
   output job_type       job
);

   logic       in_valid_ff, in_valid_in;
   item_type   in_ff;
   logic       mode_ff;
   logic [9:0] g0_ff, g0_in;
   logic [9:0] g1_ff, g1_in;
   logic       no_out;
   logic       in_go;
   hdr_type    hdr;
   logic [1:0] nbytes;
   logic [7:0] gr;
   logic [9:0] desig;
   logic [9:0] cur;

   // Work out the header, code bytes and new designations of the held word.
   always_comb begin
      no_out = 1'b0;
      hdr    = HDR_NONE;
      nbytes = 2'd1;
      gr     = 8'h00;
      g0_in  = g0_ff;
      g1_in  = g1_ff;
      desig  = {1'b0, in_ff.cls[0], in_ff.fin};
      cur    = in_ff.cls[1] ? g1_ff : g0_ff;
      if (in_ff.op == OP_REINIT) begin
         no_out = 1'b1;
         g0_in  = G0_RESET;
         g1_in  = G1_RESET;
      end else begin
         case (in_ff.cls)
            CLS_94SB, CLS_94MB, CLS_96SB, CLS_96MB: begin
               nbytes = in_ff.sz[1] ? 2'd2 : 2'd1;
               gr     = {in_ff.cls[1], 7'b0};
               if (cur != desig) begin
                  if (in_ff.cls[1]) begin
                     hdr   = in_ff.cls[0] ? HDR_G1_MB : HDR_G1_SB;
                     g1_in = desig;
                  end else begin
                     hdr   = in_ff.cls[0] ? HDR_G0_MB : HDR_G0_SB;
                     g0_in = desig;
                  end
               end
            end
            CLS_BIG5, CLS_HKSCS: begin
               nbytes = 2'd2;
               if (mode_ff) begin
                  hdr   = HDR_BIG5_OLD;
                  g0_in = DESIG_BIG5;
                  g1_in = DESIG_BIG5;
               end else begin
                  hdr = HDR_BIG5;
               end
            end
            CLS_GBK: begin
               nbytes = 2'd2;
               hdr    = HDR_GBK;
            end
            CLS_ISCII:  hdr = HDR_ISCII;
            CLS_KOI8R:  hdr = HDR_KOI8R;
            CLS_KOI8U:  hdr = HDR_KOI8U;
            CLS_VISCII: hdr = HDR_VISCII;
            default:    no_out = 1'b1;
         endcase
      end
   end

   // Job toward the emitter.
   always_comb begin
      job.hdr     = hdr;
      job.fin     = in_ff.fin;
      job.hdr_len = hdr_len(hdr);
      job.total   = hdr_len(hdr) + CNT_W'(nbytes);
      job.b0      = in_ff.b0 | gr;
      job.b1      = in_ff.b1 | gr;
   end

   // A word leaves at once when it sends nothing, else when the emitter takes it.
   assign job_valid   = in_valid_ff && !no_out;
   assign in_go       = in_valid_ff && (no_out || job_ready);
   assign item_ready  = !in_valid_ff || in_go;
   assign in_valid_in = item_valid || (in_valid_ff && !in_go);

   // Control state, designations and mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= 1'b0;
         g0_ff       <= G0_RESET;
         g1_ff       <= G1_RESET;
      end else begin
         in_valid_ff <= item_ready ? item_valid : in_valid_in;
         if (csr_valid) begin
            mode_ff <= csr_data;
         end
         if (in_go) begin
            g0_ff <= g0_in;
            g1_ff <= g1_in;
         end
      end
   end

   // Input word register.
   always_ff @(posedge clock) begin
      if (item_valid && item_ready) begin
         in_ff <= item;
      end
   end

endmodule

`default_nettype wire

// ----- design/cte_emit.sv -----
// ----------------------------------------------------------------------------
// Compound text byte emitter
// Steps through the header and code bytes of one job, one byte per cycle while
// rsp is not stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "compound_text_encoder_assert.svh"

module cte_emit
   import cte_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   output logic         job_ready,
   input  wire job_type job,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tlast
);

   logic             job_valid_ff;
   job_type          job_ff;
   logic [CNT_W-1:0] idx_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff;
   logic             emit_adv;
   logic             emit_last;
   logic             job_load;

   assign emit_adv  = job_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign emit_last = idx_ff == (job_ff.total - CNT_W'(1));
   assign job_ready = !job_valid_ff || (emit_adv && emit_last);
   assign job_load  = job_valid && job_ready;

   // Byte at the current position: header, then first and second code byte.
   always_comb begin
      if (idx_ff < job_ff.hdr_len) begin
         rsp_data_in = hdr_byte(job_ff.hdr, idx_ff, job_ff.fin);
      end else if (idx_ff == job_ff.hdr_len) begin
         rsp_data_in = job_ff.b0;
      end else begin
         rsp_data_in = job_ff.b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (job_ready) begin
            job_valid_ff <= job_valid;
         end
         if (emit_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Job register, byte position and output word.
   always_ff @(posedge clock) begin
      if (job_load) begin
         job_ff <= job;
         idx_ff <= '0;
      end else if (emit_adv) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
      if (emit_adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `CTE_ASSERT(a_idx_in_range, job_valid_ff |-> (idx_ff < job_ff.total), "index past end")
   `CTE_ASSERT(a_code_byte_sent, job_valid_ff |-> (job_ff.hdr_len < job_ff.total), "no code byte")
   `CTE_ASSERT(a_job_retires, (emit_adv && emit_last && !job_valid) |=> !job_valid_ff,
               "finished job still held")
   `CTE_ASSERT_ALWAYS(a_reset_idle, reset |=> (!job_valid_ff && !rsp_valid_ff), "busy after reset")

endmodule

`default_nettype wire

// ----- verif/tb_compound_text_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compound text encoder testbench
// Sends classified characters, predicts the compound text byte stream in
// parallel and checks every output word against it; all but the last phase
// stall both sides at random; the Big5 old-server mode changes between phases.
// ----------------------------------------------------------------------------

module tb_compound_text_encoder;
   import cte_pkg::*;

   localparam int IDLE_PCT   = 27;
   localparam int STALL_MAX  = 3000;
   localparam int SETTLE     = 8;

   // Range of class codes that no encoder handles.
   localparam logic [3:0] CLS_UNSUP_LO = 4'd11;
   localparam logic [3:0] CLS_UNSUP_HI = 4'd15;

   // Extended segment framing bytes.
   localparam logic [7:0] EXT_PCT    = 8'h25;
   localparam logic [7:0] EXT_SLASH  = 8'h2F;
   localparam logic [7:0] EXT_DIGIT0 = 8'h30;
   localparam logic [7:0] EXT_LEN_HI = 8'h80;
   localparam logic [7:0] EXT_STX    = 8'h02;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // final_byte, char_size, code_byte_0, code_byte_1
   logic [4:0]  req_tuser = '0;   // operation, char_class
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // out_byte
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;

   // Predictor state: mode register and the two designations.
   logic        big5_old_mode = 1'b0;
   logic [9:0]  g0_desig = G0_RESET;
   logic [9:0]  g1_desig = G1_RESET;

   item_type     chars_to_send[$];
   item_type     char_held;
   logic [7:0]   char_bytes[$];
   out_word_type bytes_due[$];
   out_word_type byte_want;
   logic         steady = 1'b0;
   int           errors = 0;
   int           stall_count = 0;

   compound_text_encoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Length pair, encoding name and STX of an extended segment.
   function automatic void put_name(input string name, input int ncode);
      char_bytes.push_back(EXT_LEN_HI);
      char_bytes.push_back(EXT_LEN_HI | 8'(name.len() + 1 + ncode));
      for (int i = 0; i < name.len(); i++) begin
         char_bytes.push_back(8'(name[i]));
      end
      char_bytes.push_back(EXT_STX);
   endfunction

   // Full extended segment header: ESC % / digit, then the name part.
   function automatic void put_segment(input string name, input int ncode);
      char_bytes.push_back(ESC_BYTE);
      char_bytes.push_back(EXT_PCT);
      char_bytes.push_back(EXT_SLASH);
      char_bytes.push_back(EXT_DIGIT0 + 8'(ncode));
      put_name(name, ncode);
   endfunction

   // Works out the bytes of one character and queues them as due.
   function automatic void encode_char(input item_type it);
      logic [9:0] want;
      logic       g1_side;
      logic [7:0] hi_bit;
      char_bytes.delete();
      if (it.op == OP_REINIT) begin
         g0_desig = G0_RESET;
         g1_desig = G1_RESET;
      end else begin
         case (it.cls)
            CLS_94SB, CLS_94MB, CLS_96SB, CLS_96MB: begin
               want    = {1'b0, it.cls[0], it.fin};
               g1_side = (it.cls == CLS_96SB) || (it.cls == CLS_96MB);
               hi_bit  = g1_side ? 8'h80 : 8'h00;
               if ((g1_side ? g1_desig : g0_desig) != want) begin
                  char_bytes.push_back(ESC_BYTE);
                  if (it.cls[0]) begin
                     char_bytes.push_back(DOLLAR_BYTE);
                  end
                  char_bytes.push_back(g1_side ? G1_INTER : G0_INTER);
                  char_bytes.push_back(it.fin);
                  if (g1_side) begin
                     g1_desig = want;
                  end else begin
                     g0_desig = want;
                  end
               end
               char_bytes.push_back(it.b0 | hi_bit);
               if (it.sz >= 2'd2) begin
                  char_bytes.push_back(it.b1 | hi_bit);
               end
            end
            CLS_BIG5, CLS_HKSCS, CLS_GBK: begin
               if (it.cls == CLS_GBK) begin
                  put_segment("gbk-0", 2);
               end else if (big5_old_mode) begin
                  // Old servers expect the name twice and lose both sets.
                  put_segment("BIG5-0", 2);
                  put_name("BIG5-0", 2);
                  g0_desig = DESIG_BIG5;
                  g1_desig = DESIG_BIG5;
               end else begin
                  put_segment("big5-0", 2);
               end
               char_bytes.push_back(it.b0);
               char_bytes.push_back(it.b1);
            end
            CLS_ISCII, CLS_KOI8R, CLS_KOI8U, CLS_VISCII: begin
               case (it.cls)
                  CLS_ISCII: put_segment("iscii-dev", 1);
                  CLS_KOI8R: put_segment("koi8-r", 1);
                  CLS_KOI8U: put_segment("koi8-u", 1);
                  default:   put_segment("viscii1.1-1", 1);
               endcase
               char_bytes.push_back(it.b0);
            end
            default: begin
               // Unsupported classes produce nothing.
            end
         endcase
      end
      foreach (char_bytes[i]) begin
         bytes_due.push_back('{data: char_bytes[i], last: (i == char_bytes.size() - 1)});
      end
   endfunction

   function automatic item_type make_char(input logic op, input logic [3:0] cls,
                                          input logic [7:0] fin, input logic [1:0] sz,
                                          input logic [7:0] b0, input logic [7:0] b1);
      item_type it;
      it.op  = op;
      it.cls = cls;
      it.fin = fin;
      it.sz  = sz;
      it.b0  = b0;
      it.b1  = b1;
      return it;
   endfunction

   // Mostly well-formed characters from a few sets so that designations
   // both repeat and change; the rest reinit, unsupported or odd sizes.
   function automatic item_type rand_char();
      item_type   it;
      int         roll;
      logic [7:0] finals [4] = '{8'h41, 8'h42, 8'h4A, 8'h4D};
      roll   = $urandom_range(99);
      it.op  = OP_ENCODE;
      it.cls = $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom_range(10));
      it.fin = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : finals[$urandom_range(3)];
      it.sz  = 2'($urandom_range(1, 2));
      it.b0  = 8'($urandom_range(255));
      it.b1  = 8'($urandom_range(255));
      if (roll < 6) begin
         it.op = OP_REINIT;
      end else if (roll < 12) begin
         it.cls = 4'($urandom_range(CLS_UNSUP_LO, CLS_UNSUP_HI));
      end else if (roll < 18) begin
         it.sz = $urandom_range(1) ? 2'd0 : 2'd3;
      end
      return it;
   endfunction

   // Character driver: holds a word until accepted, then offers the next.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            encode_char(char_held);
         end
         if (!req_tvalid || req_tready) begin
            if (chars_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               char_held = chars_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {6'b0, char_held.b1, char_held.b0, char_held.sz, char_held.fin};
               req_tuser  <= {char_held.cls, char_held.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Byte monitor and random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (bytes_due.size() == 0) begin
               $display("%0t: unexpected word: byte %02h last %0b", $time, rsp_tdata,
                        rsp_tlast);
               errors++;
            end else begin
               byte_want = bytes_due.pop_front();
               if (rsp_tdata !== byte_want.data) begin
                  $display("%0t: out_byte mismatch: expected %02h, actual %02h", $time,
                           byte_want.data, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== byte_want.last) begin
                  $display("%0t: last_byte mismatch: expected %0b, actual %0b", $time,
                           byte_want.last, rsp_tlast);
                  errors++;
               end
            end
         end
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            stall_count = 0;
         end else begin
            stall_count++;
         end
         if (stall_count >= STALL_MAX) begin
            $display("%0t: no progress on any channel", $time);
            $display("** compound_text_encoder: FAILED **");
            $finish;
         end
      end
   end

   // Waits until every character is sent and every byte is back, then lets
   // the block settle, since reinit and unsupported words leave no trace.
   task automatic drain();
      do begin
         @(posedge clock);
      end while (chars_to_send.size() != 0 || req_tvalid || bytes_due.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      big5_old_mode = mode;
   endtask

   task automatic send_random(input int count);
      item_type it;
      int       sent;
      sent = 0;
      while (sent < count) begin
         it = rand_char();
         chars_to_send.push_back(it);
         if (it.op == OP_REINIT || it.cls <= CLS_VISCII) begin
            sent++;
         end
      end
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b0);

      // Designations, sizes, every class and the no-result cases.
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_94SB, 8'h42, 2'd1, 8'h00, 8'hFF));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_94SB, 8'h00, 2'd2, 8'hFF, 8'h7F));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_94MB, 8'hFF, 2'd2, 8'h21, 8'h7E));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_94MB, 8'hFF, 2'd0, 8'h30, 8'h31));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_96SB, 8'h41, 2'd1, 8'h7F, 8'h00));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_96MB, 8'h40, 2'd3, 8'h00, 8'hFF));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_BIG5, 8'h00, 2'd1, 8'hFF, 8'h00));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_HKSCS, 8'hFF, 2'd2, 8'h88, 8'h40));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_GBK, 8'h55, 2'd1, 8'h81, 8'hFE));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_ISCII, 8'h00, 2'd2, 8'hA1, 8'h55));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_KOI8R, 8'h00, 2'd1, 8'hC1, 8'hAA));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_KOI8U, 8'hAA, 2'd3, 8'hA4, 8'h00));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_VISCII, 8'h41, 2'd1, 8'hFF, 8'hFF));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_UNSUP_LO, 8'h42, 2'd1, 8'h41, 8'h00));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_UNSUP_HI, 8'hFF, 2'd3, 8'hFF, 8'hFF));
      chars_to_send.push_back(make_char(OP_REINIT, CLS_94SB, 8'h00, 2'd0, 8'h00, 8'h00));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_94SB, 8'h42, 2'd1, 8'h41, 8'h00));
      drain();

      // Old-server Big5 replaces both designations with the marker.
      write_mode(1'b1);
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_BIG5, 8'h42, 2'd2, 8'hA4, 8'h40));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_94SB, 8'h42, 2'd1, 8'h41, 8'h00));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_HKSCS, 8'h00, 2'd1, 8'h87, 8'h41));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_96SB, 8'h41, 2'd1, 8'h20, 8'h00));
      drain();

      // Normal Big5 leaves the designations alone.
      write_mode(1'b0);
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_BIG5, 8'h41, 2'd2, 8'hA4, 8'hA1));
      chars_to_send.push_back(make_char(OP_ENCODE, CLS_96SB, 8'h41, 2'd1, 8'h20, 8'h00));
      chars_to_send.push_back(make_char(OP_REINIT, CLS_UNSUP_HI, 8'hFF, 2'd3, 8'hFF, 8'hFF));
      drain();

      // Random phases: normal mode, old-server mode, then with no stalls.
      send_random(50);
      write_mode(1'b1);
      send_random(50);
      write_mode(1'b0);
      steady = 1'b1;
      send_random(50);
      steady = 1'b0;

      if (errors == 0) begin
         $display("** compound_text_encoder: PASSED **");
      end else begin
         $display("** compound_text_encoder: FAILED **");
      end
      $finish;
   end

endmodule
